/* rtl/pdp_pkg.sv */
// Package for the packet departure pacer: field widths, protocol constants,
// register indexes, state and mode types. No dependencies.
`default_nettype none

package pdp_pkg;

   // Fixed-point fraction bits of the speed and rate registers.
   localparam int FRAC_BITS = 16;

   localparam int TIME_W     = 63;
   localparam int LEN_W      = 16;
   localparam int TRACE_W    = 40;
   localparam int RATE_W     = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 63;

   // A clamped trace timestamp never exceeds 60 s, which fits in 36 bits.
   localparam int TRACE_CLAMP_W = 36;
   localparam int DIVIDEND_W    = TRACE_CLAMP_W + FRAC_BITS;
   localparam int DIVISOR_W     = RATE_W;
   localparam int DIV_CNT_W     = $clog2(DIVIDEND_W);

   localparam logic [TIME_W-1:0]  TIME_MAX       = '1;
   localparam logic [TRACE_W-1:0] LONG_TRACE_NS  = TRACE_W'(64'd60000000000);
   localparam logic [TRACE_CLAMP_W-1:0] LONG_TRACE_SUB = TRACE_CLAMP_W'(100);

   localparam int BIT_GAP_W = 13;
   localparam int BIT_PROD_W = LEN_W + BIT_GAP_W;
   localparam logic [DIVIDEND_W-1:0] PKT_GAP_NUM = DIVIDEND_W'(1000);
   localparam logic [BIT_PROD_W-1:0] BIT_GAP_NUM = BIT_PROD_W'(8000);

   localparam logic [RATE_W-1:0] SPEED_RESET = RATE_W'(64'd1 << FRAC_BITS);
   localparam logic [RATE_W-1:0] MIN_SPEED   = RATE_W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_START_TIME = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEED      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_PKT   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_BIT   = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_TARGET,
      S_RELEASE,
      S_UPDATE
   } pdp_state_type;

   typedef enum logic [1:0] {
      MODE_TRACE,
      MODE_PKT,
      MODE_BIT
   } pdp_mode_type;

endpackage

`default_nettype wire

/* rtl/pdp_if.sv */
// Valid/ready channel interfaces for the packet departure pacer.
// Depends on pdp_pkg for the field widths.
`default_nettype none

interface pdp_req_if;
   import pdp_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [TIME_W-1:0]    now_ns;
   logic [LEN_W-1:0]     pkt_len_bytes;
   logic [TRACE_W-1:0]   trace_time_ns;

   modport source (output valid, now_ns, pkt_len_bytes, trace_time_ns, input ready);
   modport sink   (input valid, now_ns, pkt_len_bytes, trace_time_ns, output ready);
endinterface

interface pdp_rsp_if;
   import pdp_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [TIME_W-1:0]    release_time_ns;
   logic                 was_held;

   modport source (output valid, release_time_ns, was_held, input ready);
   modport sink   (input valid, release_time_ns, was_held, output ready);
endinterface

`default_nettype wire

/* rtl/packet_departure_pacer.sv */
// Top level of the packet departure pacer: configuration registers, control
// sequencer and result register. Depends on pdp_pkg, pdp_if and pdp_divider.
//
// Usage: each beat on the req channel carries one packet's current time,
// length and trace timestamp; exactly one beat comes back on the rsp channel
// with the release time and a flag telling whether the packet was held.
// The csr port writes start time, playback speed, packet rate and bit rate;
// write it only while no packet is in flight.
// Steps: after the edge that accepts the request beat, the bit-serial
// divider produces one quotient bit per cycle; the target add, the compare
// and the next-departure add then follow in that order in the sequencer
// states S_TARGET, S_RELEASE and S_UPDATE, and S_UPDATE loads the result.
// The block takes one packet at a time, and req.ready is high whenever it
// is idle.
// The result sits in an output register, so a new request is taken while
// the previous result still waits for the receiver. If the receiver stalls
// long enough that the next result is ready before the old one is taken,
// the sequencer holds in its last step until the output register frees.
// Reset restores the register defaults (speed 1.0, rates zero, start time
// zero), clears the stored next departure and drops any pending result.
`default_nettype none

module packet_departure_pacer (
   input  logic                              clock,
   input  logic                              reset,
   pdp_req_if.sink                           req,
   pdp_rsp_if.source                         rsp,
   input  logic                              csr_we,
   input  logic [pdp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [pdp_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import pdp_pkg::*;

   // Saturating time add; both operands stay within the 63-bit time range,
   // so the 64-bit sum never wraps.
   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
      logic [TIME_W:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      if (sum >= {1'b0, TIME_MAX}) begin
         return TIME_MAX;
      end
      return sum[TIME_W-1:0];
   endfunction

   // Configuration registers.
   logic [TIME_W-1:0] start_time_ff, start_time_in;
   logic [RATE_W-1:0] speed_ff, speed_in;
   logic [RATE_W-1:0] rate_pkt_ff, rate_pkt_in;
   logic [RATE_W-1:0] rate_bit_ff, rate_bit_in;

   // Sequencer and per-packet working registers.
   pdp_state_type     state_ff, state_in;
   pdp_mode_type      mode_ff, mode_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [TIME_W-1:0] target_ff, target_in;
   logic [TIME_W-1:0] release_ff, release_in;
   logic              held_ff, held_in;
   logic [TIME_W-1:0] next_dep_ff, next_dep_in;

   // Output register.
   logic              rsp_valid_ff, rsp_valid_in;
   logic [TIME_W-1:0] rsp_release_ff, rsp_release_in;
   logic              rsp_held_ff, rsp_held_in;

   // Control decoded from the state.
   logic req_ready;
   logic req_accept;
   logic tgt_load;
   logic rel_load;
   logic rsp_load;
   logic rsp_free;

   // Divider operands.
   pdp_mode_type             mode_sel;
   logic [TRACE_CLAMP_W-1:0] ts_clamped;
   logic [BIT_PROD_W-1:0]    bit_prod;
   logic [DIVIDEND_W-1:0]    div_dividend;
   logic [DIVISOR_W-1:0]     div_divisor;
   logic                     div_done;
   logic [DIVIDEND_W-1:0]    div_quotient;
   logic [TIME_W-1:0]        quo_time;

   assign req_accept = req.valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp.ready;
   assign quo_time   = TIME_W'(div_quotient);

   // Configuration writes.
   always_comb begin
      start_time_in = start_time_ff;
      speed_in      = speed_ff;
      rate_pkt_in   = rate_pkt_ff;
      rate_bit_in   = rate_bit_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_START_TIME: start_time_in = csr_wdata;
            CSR_SPEED:      speed_in      = csr_wdata[RATE_W-1:0];
            CSR_RATE_PKT:   rate_pkt_in   = csr_wdata[RATE_W-1:0];
            CSR_RATE_BIT:   rate_bit_in   = csr_wdata[RATE_W-1:0];
            default: ;
         endcase
      end
   end

   // Mode selection and divider operands, formed from the request beat.
   // A packet rate takes precedence over a bit rate; with both zero the
   // trace timestamp is scaled by the playback speed.
   always_comb begin
      if (rate_pkt_ff != '0) begin
         mode_sel = MODE_PKT;
      end else if (rate_bit_ff != '0) begin
         mode_sel = MODE_BIT;
      end else begin
         mode_sel = MODE_TRACE;
      end

      // Timestamps beyond one minute are treated as bogus and replaced.
      ts_clamped = (req.trace_time_ns > LONG_TRACE_NS) ? LONG_TRACE_SUB
                                                       : req.trace_time_ns[TRACE_CLAMP_W-1:0];
      bit_prod = BIT_PROD_W'(req.pkt_len_bytes) * BIT_GAP_NUM;

      case (mode_sel)
         MODE_PKT: begin
            div_dividend = PKT_GAP_NUM << FRAC_BITS;
            div_divisor  = rate_pkt_ff;
         end
         MODE_BIT: begin
            div_dividend = DIVIDEND_W'(bit_prod) << FRAC_BITS;
            div_divisor  = rate_bit_ff;
         end
         default: begin
            div_dividend = {ts_clamped, {FRAC_BITS{1'b0}}};
            div_divisor  = (speed_ff < MIN_SPEED) ? MIN_SPEED : speed_ff;
         end
      endcase
   end

   pdp_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (req_accept),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:    if (req.valid) state_in = S_DIV;
         S_DIV:     if (div_done) state_in = S_TARGET;
         S_TARGET:  state_in = S_RELEASE;
         S_RELEASE: state_in = S_UPDATE;
         S_UPDATE:  if (rsp_free) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_ready = 1'b0;
      tgt_load  = 1'b0;
      rel_load  = 1'b0;
      rsp_load  = 1'b0;
      case (state_ff)
         S_IDLE:    req_ready = 1'b1;
         S_TARGET:  tgt_load  = 1'b1;
         S_RELEASE: rel_load  = 1'b1;
         S_UPDATE:  rsp_load  = rsp_free;
         default: ;
      endcase
   end

   // Datapath.
   always_comb begin
      mode_in     = req_accept ? mode_sel : mode_ff;
      now_in      = req_accept ? req.now_ns : now_ff;
      target_in   = target_ff;
      release_in  = release_ff;
      held_in     = held_ff;
      next_dep_in = next_dep_ff;

      // In trace mode the target is the scaled timestamp past the start
      // time; in a rate mode it is the stored next departure.
      if (tgt_load) begin
         target_in = (mode_ff == MODE_TRACE) ? sat_add(start_time_ff, quo_time)
                                             : next_dep_ff;
      end

      if (rel_load) begin
         held_in    = target_ff > now_ff;
         release_in = (target_ff > now_ff) ? target_ff : now_ff;
         if (mode_ff == MODE_TRACE) begin
            next_dep_in = target_ff;
         end
      end

      // In a rate mode the next packet is spaced one gap after this release.
      if (rsp_load && (mode_ff != MODE_TRACE)) begin
         next_dep_in = sat_add(release_ff, quo_time);
      end
   end

   always_comb begin
      rsp_release_in = rsp_release_ff;
      rsp_held_in    = rsp_held_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      if (rsp_load) begin
         rsp_release_in = release_ff;
         rsp_held_in    = held_ff;
         rsp_valid_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_time_ff <= '0;
         speed_ff      <= SPEED_RESET;
         rate_pkt_ff   <= '0;
         rate_bit_ff   <= '0;
         state_ff      <= S_IDLE;
         next_dep_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         start_time_ff <= start_time_in;
         speed_ff      <= speed_in;
         rate_pkt_ff   <= rate_pkt_in;
         rate_bit_ff   <= rate_bit_in;
         state_ff      <= state_in;
         next_dep_ff   <= next_dep_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      mode_ff        <= mode_in;
      now_ff         <= now_in;
      target_ff      <= target_in;
      release_ff     <= release_in;
      held_ff        <= held_in;
      rsp_release_ff <= rsp_release_in;
      rsp_held_ff    <= rsp_held_in;
   end

   assign req.ready           = req_ready;
   assign rsp.valid           = rsp_valid_ff;
   assign rsp.release_time_ns = rsp_release_ff;
   assign rsp.was_held        = rsp_held_ff;

`ifndef SYNTH
   // The divider finishes only while the sequencer waits for it.
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("divider finished outside the divide step");

   // An accepted request always starts the divide step.
   a_accept_starts_div: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == S_DIV))
      else $error("accepted request did not start a division");

   // A packet is never released before it was offered, and a held packet
   // leaves exactly at its target.
   a_release_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UPDATE) |->
         (release_ff >= now_ff) && (!held_ff || (release_ff == target_ff)))
      else $error("release time inconsistent with offer time or target");
`endif

endmodule

`default_nettype wire

/* rtl/pdp_divider.sv */
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on pdp_pkg for the dividend and divisor widths.
`default_nettype none

module pdp_divider (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [pdp_pkg::DIVIDEND_W-1:0]   dividend,
   input  logic [pdp_pkg::DIVISOR_W-1:0]    divisor,
   output logic                             done,
   output logic [pdp_pkg::DIVIDEND_W-1:0]   quotient
);
   import pdp_pkg::*;

   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;

   logic [DIVISOR_W:0]    rem_shift;
   logic [DIVISOR_W+1:0]  diff;
   logic                  fits;

   // The dividend shifts out of the top of quo_ff while quotient bits
   // shift in at the bottom.
   assign rem_shift = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff      = {1'b0, rem_shift} - {2'b00, dvs_ff};
   assign fits      = ~diff[DIVISOR_W+1];

   assign done     = busy_ff && (cnt_ff == '0);
   assign quotient = quo_ff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         cnt_in  = DIV_CNT_W'(DIVIDEND_W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in = fits ? diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

endmodule

`default_nettype wire
